>>> sv/mqjd_pkg.sv
// shared types, codes and default sizes for the multi-queue job dispatcher
// no dependencies; imported by every module of the block
package mqjd_pkg;

    // fixed field widths of the item ports
    localparam int ACTION_W   = 2;
    localparam int QIDX_W     = 3;
    localparam int HANDLE_W   = 16;
    localparam int STATUS_W   = 2;
    localparam int CFG_W      = 4;

    // default sizes
    localparam int DEF_NUM_QUEUES = 8;
    localparam int DEF_FIFO_DEPTH = 16;
    localparam int DEF_JOB_WIDTH  = 16;

    // reset value of the active queue count register
    localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd1;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SET   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_GET   = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_JOB    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_BAD_INDEX = 2'd3;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_READ,
        ST_FINISH
    } ctl_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic scan_step;
        logic read_done;
        logic out_load;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic is_get;
        logic slot_hit;
        logic nonempty;
        logic scan_last;
    } dp_sts_t;

endpackage

>>> sv/mqjd_ctrl.sv
// controller state machine of the multi-queue job dispatcher
// depends on mqjd_pkg; drives datapath commands and the channel handshakes
module mqjd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  mqjd_pkg::dp_sts_t sts,
    output mqjd_pkg::dp_cmd_t cmd
);
    import mqjd_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    // output register can take a new result
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = sts.is_get ? ST_SCAN : ST_FINISH;
            end
            ST_SCAN:
            begin
                if (sts.slot_hit)
                    state_next = ST_FINISH;
                else if (sts.nonempty)
                    state_next = ST_READ;
                else if (sts.scan_last)
                    state_next = ST_FINISH;
            end
            ST_READ:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:   cmd.capture   = in_valid;
            ST_EXEC:   cmd.exec      = 1'b1;
            ST_SCAN:   cmd.scan_step = 1'b1;
            ST_READ:   cmd.read_done = 1'b1;
            ST_FINISH: cmd.out_load  = out_free;
            default:   cmd           = '0;
        endcase
    end

    // output valid follows loads and transfers
    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> sv/mqjd_datapath.sv
// datapath of the multi-queue job dispatcher: queue pointers, slots, job memory
// depends on mqjd_pkg; sequenced by mqjd_ctrl through dp_cmd_t / dp_sts_t
module mqjd_datapath #(
    parameter int NUM_QUEUES = mqjd_pkg::DEF_NUM_QUEUES,
    parameter int FIFO_DEPTH = mqjd_pkg::DEF_FIFO_DEPTH,
    parameter int JOB_WIDTH  = mqjd_pkg::DEF_JOB_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mqjd_pkg::CFG_W-1:0]      cfg_data,
    input  logic [mqjd_pkg::ACTION_W-1:0]   action,
    input  logic [mqjd_pkg::QIDX_W-1:0]     queue_index,
    input  logic [mqjd_pkg::HANDLE_W-1:0]   job_handle,
    input  mqjd_pkg::dp_cmd_t               cmd,
    output mqjd_pkg::dp_sts_t               sts,
    output logic [mqjd_pkg::STATUS_W-1:0]   status,
    output logic [mqjd_pkg::HANDLE_W-1:0]   job_out,
    output logic [mqjd_pkg::QIDX_W-1:0]     source_queue,
    output logic                            from_slot,
    output logic                            slot_occupied
);
    import mqjd_pkg::*;

    localparam int QW        = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int NW        = $clog2(NUM_QUEUES + 1);
    localparam int CW        = (NW > CFG_W) ? NW : CFG_W;
    localparam int PW        = $clog2(FIFO_DEPTH);
    localparam int FW        = $clog2(FIFO_DEPTH + 1);
    localparam int AW        = QW + PW;
    localparam int MEM_DEPTH = 1 << AW;

    // configuration and captured request
    logic [CFG_W-1:0]     active_reg;
    logic [ACTION_W-1:0]  req_action_reg;
    logic [QIDX_W-1:0]    req_q_reg;
    logic [JOB_WIDTH-1:0] req_job_reg;

    // per-queue control state
    logic [PW-1:0]         head_reg  [NUM_QUEUES];
    logic [PW-1:0]         tail_reg  [NUM_QUEUES];
    logic [FW-1:0]         count_reg [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] slot_valid_reg;
    logic [JOB_WIDTH-1:0]  slot_job_reg [NUM_QUEUES];

    // scan position
    logic [QW-1:0] scan_idx_reg;
    logic [QW-1:0] scan_idx_next;
    logic [CW-1:0] scan_cnt_reg;

    // job memory, one region of 2**PW entries per queue
    logic [JOB_WIDTH-1:0] mem [MEM_DEPTH];
    logic [JOB_WIDTH-1:0] mem_rd_reg;

    // pending result
    logic [STATUS_W-1:0]  res_status_reg;
    logic [JOB_WIDTH-1:0] res_job_reg;
    logic [QW-1:0]        res_src_reg;
    logic                 res_slot_reg;

    // output register
    logic [STATUS_W-1:0]  status_reg;
    logic [HANDLE_W-1:0]  job_out_reg;
    logic [QIDX_W-1:0]    source_queue_reg;
    logic                 from_slot_reg;
    logic                 slot_occupied_reg;

    logic [CW-1:0] act_ext;
    logic [CW-1:0] n_cnt;
    logic [CW-1:0] q_ext;
    logic [CW-1:0] scan_ext;
    logic [CW-1:0] scan_nxt_ext;
    logic [QW-1:0] q_idx;
    logic          q_ok;
    logic          q_in_range;
    logic          add_full;
    logic          slot_hit;
    logic          nonempty;
    logic          scan_last;
    logic [PW-1:0] tail_q;
    logic [PW-1:0] head_s;

    // active queue count saturated into 1..NUM_QUEUES
    always_comb
    begin
        act_ext = CW'(active_reg);
        if (act_ext == '0)
            n_cnt = CW'(1);
        else if (act_ext > CW'(NUM_QUEUES))
            n_cnt = CW'(NUM_QUEUES);
        else
            n_cnt = act_ext;
    end

    // request decode
    assign q_ext      = CW'(req_q_reg);
    assign q_idx      = QW'(req_q_reg);
    assign q_ok       = q_ext < n_cnt;
    assign q_in_range = q_ext < CW'(NUM_QUEUES);
    assign tail_q     = tail_reg[q_idx];
    assign add_full   = count_reg[q_idx] >= FW'(FIFO_DEPTH);

    // scan step checks on the current queue
    assign scan_ext     = CW'(scan_idx_reg);
    assign scan_nxt_ext = scan_ext + CW'(1);
    assign head_s       = head_reg[scan_idx_reg];
    assign slot_hit     = (scan_ext == q_ext) && slot_valid_reg[scan_idx_reg];
    assign nonempty     = count_reg[scan_idx_reg] != '0;
    assign scan_last    = (scan_cnt_reg + CW'(1)) >= n_cnt;
    assign scan_idx_next = (scan_nxt_ext >= n_cnt) ? '0 : QW'(scan_nxt_ext);

    assign sts.is_get    = (req_action_reg == ACT_GET);
    assign sts.slot_hit  = slot_hit;
    assign sts.nonempty  = nonempty;
    assign sts.scan_last = scan_last;

    // control state: config, pointers, counts, slot valid bits, scan position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= ACTIVE_RESET;
            slot_valid_reg <= '0;
            scan_idx_reg   <= '0;
            scan_cnt_reg   <= '0;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
                active_reg <= cfg_data;

            if (cmd.exec)
            begin
                if (req_action_reg == ACT_GET)
                begin
                    scan_idx_reg <= q_ok ? q_idx : '0;
                    scan_cnt_reg <= '0;
                end
                else if (q_ok)
                begin
                    case (req_action_reg)
                        ACT_ADD:
                        begin
                            if (!add_full)
                            begin
                                tail_reg[q_idx]  <= (tail_q == PW'(FIFO_DEPTH - 1)) ?
                                                    '0 : tail_q + PW'(1);
                                count_reg[q_idx] <= count_reg[q_idx] + FW'(1);
                            end
                        end
                        ACT_SET:   slot_valid_reg[q_idx] <= 1'b1;
                        ACT_CLEAR: slot_valid_reg[q_idx] <= 1'b0;
                        default:   slot_valid_reg <= slot_valid_reg;
                    endcase
                end
            end

            if (cmd.scan_step && !slot_hit)
            begin
                if (nonempty)
                begin
                    head_reg[scan_idx_reg]  <= (head_s == PW'(FIFO_DEPTH - 1)) ?
                                               '0 : head_s + PW'(1);
                    count_reg[scan_idx_reg] <= count_reg[scan_idx_reg] - FW'(1);
                end
                else
                begin
                    scan_idx_reg <= scan_idx_next;
                    scan_cnt_reg <= scan_cnt_reg + CW'(1);
                end
            end
        end
    end

    // request capture, slot jobs and pending result
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_action_reg <= action;
            req_q_reg      <= queue_index;
            req_job_reg    <= JOB_WIDTH'(job_handle);
        end

        if (cmd.exec)
        begin
            res_status_reg <= STAT_OK;
            res_job_reg    <= '0;
            res_src_reg    <= '0;
            res_slot_reg   <= 1'b0;
            if (req_action_reg != ACT_GET)
            begin
                if (!q_ok)
                    res_status_reg <= STAT_BAD_INDEX;
                else if (req_action_reg == ACT_ADD && add_full)
                    res_status_reg <= STAT_FULL;
                else if (req_action_reg == ACT_SET)
                    slot_job_reg[q_idx] <= req_job_reg;
            end
        end

        if (cmd.scan_step)
        begin
            if (slot_hit)
            begin
                res_job_reg  <= slot_job_reg[scan_idx_reg];
                res_src_reg  <= scan_idx_reg;
                res_slot_reg <= 1'b1;
            end
            else if (nonempty)
                res_src_reg <= scan_idx_reg;
            else if (scan_last)
                res_status_reg <= STAT_NO_JOB;
        end

        if (cmd.read_done)
            res_job_reg <= mem_rd_reg;
    end

    // job memory: push on add, registered read on pop
    always_ff @(posedge clk)
    begin
        if (cmd.exec && req_action_reg == ACT_ADD && q_ok && !add_full)
            mem[{q_idx, tail_q}] <= req_job_reg;
        if (cmd.scan_step && !slot_hit && nonempty)
            mem_rd_reg <= mem[{scan_idx_reg, head_s}];
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_reg        <= res_status_reg;
            job_out_reg       <= HANDLE_W'(res_job_reg);
            source_queue_reg  <= QIDX_W'(res_src_reg);
            from_slot_reg     <= res_slot_reg;
            slot_occupied_reg <= q_in_range && slot_valid_reg[q_idx];
        end
    end

    assign status        = status_reg;
    assign job_out       = job_out_reg;
    assign source_queue  = source_queue_reg;
    assign from_slot     = from_slot_reg;
    assign slot_occupied = slot_occupied_reg;

endmodule

>>> sv/multi_queue_job_dispatcher.sv
// Multi-queue job dispatcher: per-queue job FIFOs plus one sticky slot job per queue.
// A new transfer is taken only while idle. Add, set and clear pass through execute and
// finish; a get passes through execute and the scan and is served from the requester's
// slot, pops a FIFO after skipping empty queues, or finds nothing in the active queues.
// The get scan checks one queue per cycle; a FIFO pop adds a step for the registered
// read of the job memory. A finished result waits in the output register while the
// next item is taken in.
// depends on mqjd_pkg, mqjd_ctrl and mqjd_datapath
module multi_queue_job_dispatcher #(
    parameter int NUM_QUEUES = mqjd_pkg::DEF_NUM_QUEUES,
    parameter int FIFO_DEPTH = mqjd_pkg::DEF_FIFO_DEPTH,
    parameter int JOB_WIDTH  = mqjd_pkg::DEF_JOB_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mqjd_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [mqjd_pkg::ACTION_W-1:0] action,
    input  logic [mqjd_pkg::QIDX_W-1:0]   queue_index,
    input  logic [mqjd_pkg::HANDLE_W-1:0] job_handle,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mqjd_pkg::STATUS_W-1:0] status,
    output logic [mqjd_pkg::HANDLE_W-1:0] job_out,
    output logic [mqjd_pkg::QIDX_W-1:0]   source_queue,
    output logic                          from_slot,
    output logic                          slot_occupied
);
    import mqjd_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // sequencing
    mqjd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // queue state and result path
    mqjd_datapath #(
        .NUM_QUEUES (NUM_QUEUES),
        .FIFO_DEPTH (FIFO_DEPTH),
        .JOB_WIDTH  (JOB_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .action        (action),
        .queue_index   (queue_index),
        .job_handle    (job_handle),
        .cmd           (cmd),
        .sts           (sts),
        .status        (status),
        .job_out       (job_out),
        .source_queue  (source_queue),
        .from_slot     (from_slot),
        .slot_occupied (slot_occupied)
    );

    // at most one datapath command per cycle
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.exec, cmd.scan_step, cmd.read_done, cmd.out_load}))
        else $error("more than one datapath command active");

    // an accepted item keeps the input side busy in the next cycle
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after transfer");

    // a slot job leaves the slot in place and reports success
    a_slot_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && from_slot) |-> (status == STAT_OK && slot_occupied))
        else $error("slot result without ok status or occupied slot");

    // failed results carry no job
    a_fail_no_job: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STAT_OK) |-> (job_out == '0 && !from_slot))
        else $error("failed result carries a job");

endmodule

>>> sim/tb_multi_queue_job_dispatcher.sv
// self-checking testbench for the multi-queue job dispatcher: directed and random job requests,
// checked against a built-in dispatch predictor, with random idling on both channels
// depends on mqjd_pkg and multi_queue_job_dispatcher
module tb_multi_queue_job_dispatcher;
    import mqjd_pkg::*;

    localparam int NQ            = DEF_NUM_QUEUES;
    localparam int DEPTH         = DEF_FIFO_DEPTH;
    localparam int SETTLE_CYCLES = 24;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [ACTION_W-1:0] act;
        logic [QIDX_W-1:0]   qidx;
        logic [HANDLE_W-1:0] handle;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] st;
        logic [HANDLE_W-1:0] job;
        logic [QIDX_W-1:0]   src;
        logic                slot_hit;
        logic                occupied;
    } result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [CFG_W-1:0]    cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [ACTION_W-1:0] action = '0;
    logic [QIDX_W-1:0]   queue_index = '0;
    logic [HANDLE_W-1:0] job_handle = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] job_out;
    logic [QIDX_W-1:0]   source_queue;
    logic                from_slot;
    logic                slot_occupied;

    multi_queue_job_dispatcher dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .queue_index   (queue_index),
        .job_handle    (job_handle),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .job_out       (job_out),
        .source_queue  (source_queue),
        .from_slot     (from_slot),
        .slot_occupied (slot_occupied)
    );

    // predictor state
    logic [CFG_W-1:0]    active_reg = ACTIVE_RESET;
    logic [HANDLE_W-1:0] fifo_mem [NQ][DEPTH];
    int                  fifo_rd [NQ];
    int                  fifo_wr [NQ];
    int                  fifo_fill [NQ];
    logic                slot_full [NQ];
    logic [HANDLE_W-1:0] slot_data [NQ];

    request_t job_requests [$];
    result_t  due_results [$];
    logic     in_taken = 1'b0;
    int       send_gap = 0;
    int       recv_gap = 0;
    bit       steady = 1'b0;
    int       mismatches = 0;

    initial
    begin
        for (int q = 0; q < NQ; q++)
        begin
            fifo_rd[q] = 0;
            fifo_wr[q] = 0;
            fifo_fill[q] = 0;
            slot_full[q] = 1'b0;
            slot_data[q] = '0;
        end
    end

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // expected result of one request, updating the predictor state
    function automatic result_t predict_dispatch(request_t r);
        result_t res;
        int      n;
        int      i;
        int      k;
        bit      found;
        res = '0;
        res.st = STAT_OK;
        n = (active_reg == 0) ? 1 : (active_reg > NQ) ? NQ : int'(active_reg);
        if (r.act == ACT_GET)
        begin
            i = (r.qidx < n) ? int'(r.qidx) : 0;
            found = 1'b0;
            for (k = 0; k < n && !found; k++)
            begin
                if (i == r.qidx && slot_full[i])
                begin
                    res.job = slot_data[i];
                    res.src = QIDX_W'(i);
                    res.slot_hit = 1'b1;
                    found = 1'b1;
                end
                else if (fifo_fill[i] > 0)
                begin
                    res.job = fifo_mem[i][fifo_rd[i]];
                    fifo_rd[i] = (fifo_rd[i] + 1) % DEPTH;
                    fifo_fill[i]--;
                    res.src = QIDX_W'(i);
                    found = 1'b1;
                end
                else
                begin
                    i = (i + 1 >= n) ? 0 : i + 1;
                end
            end
            if (!found)
                res.st = STAT_NO_JOB;
        end
        else if (r.qidx >= n)
        begin
            res.st = STAT_BAD_INDEX;
        end
        else if (r.act == ACT_ADD)
        begin
            if (fifo_fill[r.qidx] >= DEPTH)
                res.st = STAT_FULL;
            else
            begin
                fifo_mem[r.qidx][fifo_wr[r.qidx]] = r.handle;
                fifo_wr[r.qidx] = (fifo_wr[r.qidx] + 1) % DEPTH;
                fifo_fill[r.qidx]++;
            end
        end
        else if (r.act == ACT_SET)
        begin
            slot_data[r.qidx] = r.handle;
            slot_full[r.qidx] = 1'b1;
        end
        else
        begin
            slot_full[r.qidx] = 1'b0;
        end
        res.occupied = slot_full[r.qidx];
        return res;
    endfunction

    // monitor: predict on each input transfer, check each output transfer
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && cfg_we)
            active_reg <= cfg_data;
        if (rst_n && in_valid && !in_stall)
            due_results.push_back(predict_dispatch('{action, queue_index, job_handle}));
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{status, job_out, source_queue, from_slot, slot_occupied};
            if (due_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: status %0d job %h src %0d slot %b occ %b",
                             got.st, got.job, got.src, got.slot_hit, got.occupied);
            end
            else
            begin
                want = due_results.pop_front();
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"result mismatch: expected status %0d job %h src %0d ",
                                  "slot %b occ %b, got status %0d job %h src %0d slot %b occ %b"},
                                 want.st, want.job, want.src, want.slot_hit, want.occupied,
                                 got.st, got.job, got.src, got.slot_hit, got.occupied);
                end
            end
        end
    end

    // request driver: hold a stalled transfer, otherwise idle or present the next request
    always @(negedge clk)
    begin
        request_t r;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !in_taken)
            ;
        else if (send_gap != 0)
        begin
            send_gap <= send_gap - 1;
            in_valid <= 1'b0;
        end
        else if (!steady && $urandom_range(0, 5) == 0)
        begin
            send_gap <= $urandom_range(0, 7);
            in_valid <= 1'b0;
        end
        else if (job_requests.size() != 0)
        begin
            r = job_requests.pop_front();
            in_valid <= 1'b1;
            action <= r.act;
            queue_index <= r.qidx;
            job_handle <= r.handle;
        end
        else
            in_valid <= 1'b0;
    end

    // result receiver: random stall bursts
    always @(negedge clk)
    begin
        if (recv_gap != 0)
        begin
            recv_gap <= recv_gap - 1;
            out_stall <= 1'b1;
        end
        else if (!steady && $urandom_range(0, 5) == 0)
        begin
            recv_gap <= $urandom_range(0, 7);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic queue_request(logic [ACTION_W-1:0] a, int q, logic [HANDLE_W-1:0] h);
        job_requests.push_back('{a, q[QIDX_W-1:0], h});
    endtask

    function automatic logic [HANDLE_W-1:0] random_handle();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            default: return HANDLE_W'($urandom);
        endcase
    endfunction

    function automatic int random_queue(int span);
        return ($urandom_range(0, 99) < 85) ? $urandom_range(0, span - 1) : $urandom_range(0, 7);
    endfunction

    // random traffic: mostly single requests, with fill bursts and drain bursts
    task automatic add_random_requests(int count, int span);
        int left;
        int burst;
        int q;
        int pick;
        logic [ACTION_W-1:0] a;
        left = count;
        while (left > 0)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                // fill one queue, often past full
                q = $urandom_range(0, span - 1);
                burst = $urandom_range(10, 20);
                for (int b = 0; b < burst && left > 0; b++, left--)
                    queue_request(ACT_ADD, q, random_handle());
            end
            else if (pick == 1)
            begin
                // drain across all queues
                burst = $urandom_range(5, 20);
                for (int b = 0; b < burst && left > 0; b++, left--)
                    queue_request(ACT_GET, random_queue(span), '0);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                a = (pick < 38) ? ACT_ADD : (pick < 50) ? ACT_SET :
                    (pick < 62) ? ACT_CLEAR : ACT_GET;
                queue_request(a, random_queue(span), random_handle());
                left--;
            end
        end
    endtask

    // wait until every request is sent and every result has come back
    task automatic wait_idle();
        while (job_requests.size() != 0 || in_valid || due_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_active(logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic int span_of(int v);
        return (v == 0) ? 1 : (v > NQ) ? NQ : v;
    endfunction

    // stimulus and verdict
    initial
    begin
        int settings [6];
        settings = '{0, 15, 3, 5, 2, 8};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // one active queue after reset: empty get, bad targets, bad requester, slot reuse
        queue_request(ACT_GET, 0, '0);
        queue_request(ACT_ADD, 0, 16'h0000);
        queue_request(ACT_ADD, 2, 16'hffff);
        queue_request(ACT_SET, 1, 16'h1111);
        queue_request(ACT_CLEAR, 7, '0);
        queue_request(ACT_GET, 5, '0);
        queue_request(ACT_SET, 0, 16'hffff);
        queue_request(ACT_GET, 0, '0);
        queue_request(ACT_ADD, 0, 16'h1234);
        queue_request(ACT_GET, 0, '0);
        queue_request(ACT_CLEAR, 0, '0);
        queue_request(ACT_GET, 0, '0);
        queue_request(ACT_GET, 7, '0);
        add_random_requests(200, 1);
        wait_idle();

        // all eight queues: scan skipping empty queues, wrap-around, slot per requester
        write_active(4'd8);
        queue_request(ACT_ADD, 7, 16'ha5a5);
        queue_request(ACT_GET, 3, '0);
        queue_request(ACT_SET, 6, 16'h0000);
        queue_request(ACT_GET, 6, '0);
        queue_request(ACT_GET, 2, '0);
        queue_request(ACT_CLEAR, 6, '0);
        queue_request(ACT_ADD, 0, 16'hffff);
        queue_request(ACT_GET, 7, '0);
        queue_request(ACT_SET, 7, 16'h5a5a);
        queue_request(ACT_GET, 7, '0);
        queue_request(ACT_CLEAR, 7, '0);
        add_random_requests(235, 8);
        wait_idle();

        foreach (settings[p])
        begin
            write_active(settings[p][CFG_W-1:0]);
            if (p == 5)
                steady = 1'b1;
            add_random_requests(235, span_of(settings[p]));
            wait_idle();
        end

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // run limit
    initial
    begin
        #4000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> files.f
sv/mqjd_pkg.sv
sv/mqjd_ctrl.sv
sv/mqjd_datapath.sv
sv/multi_queue_job_dispatcher.sv
sim/tb_multi_queue_job_dispatcher.sv
